// ===== design/bpl_pkg.sv =====
// Shared types and codes for the bounded positional list.
package bpl_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_END = 3'd3,
    OP_DEL_POS = 3'd4,
    OP_DUMP = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_NEG = 3'd3,
    ST_FULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_DUMP
  } state_e;

  localparam int unsigned OpWidth = 3;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth = 16;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned CountWidth = 6;

endpackage

// ===== design/bpl_if.sv =====
// Valid/ready channel interfaces for the list's request and result beats.
interface bpl_req_if
  import bpl_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic [OpWidth-1:0]            opcode;
  logic signed [ValueWidth-1:0]  item_value;
  logic signed [PosWidth-1:0]    slot_index;
  modport source (output valid, opcode, item_value, slot_index, input ready);
  modport sink (input valid, opcode, item_value, slot_index, output ready);
endinterface

interface bpl_rsp_if
  import bpl_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic [StatusWidth-1:0]        status;
  logic signed [ValueWidth-1:0]  element;
  logic [CountWidth-1:0]         element_count;
  logic                          last_of_run;
  modport source (output valid, status, element, element_count, last_of_run, input ready);
  modport sink (input valid, status, element, element_count, last_of_run, output ready);
endinterface

// ===== design/bpl_mem.sv =====
// Slot store: element and link words, one write and one registered read port.
module bpl_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WORD_WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WORD_WIDTH-1:0] wword_i,
  input  logic [AW-1:0]         wlink_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WORD_WIDTH-1:0] rword_o,
  output logic [AW-1:0]         rlink_o
);

  logic [WORD_WIDTH-1:0] word_mem [DEPTH];
  logic [AW-1:0]         link_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      word_mem[waddr_i] <= wword_i;
      link_mem[waddr_i] <= wlink_i;
    end
    rword_o <= word_mem[raddr_i];
    rlink_o <= link_mem[raddr_i];
  end

endmodule

// ===== design/bounded_positional_list_unit.sv =====
// Bounded positional list: request decode, list walk sequencer and result register.
// Errors, unused opcodes and front inserts load the result at the accept edge; deletes
// and inserts past the front walk the list in S_WALK and load it there (front delete) or
// in S_LINK. Dump loads its first beat in the cycle after accept, then one beat per cycle
// the sink takes. Only one request is in flight; the next is accepted at the edge its
// last beat leaves.
// Reset (rst_ni low, asynchronous) empties the list; slot contents stay undefined.
module bounded_positional_list_unit
  import bpl_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  bpl_req_if.sink   req,
  bpl_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [DEPTH-1:0] free_q, free_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    steps_q, steps_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic             ins_q, ins_d;
  logic             front_q, front_d;
  logic [WORD_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0]    nslot_q, nslot_d;

  logic                  ovalid_q, ovalid_d;
  logic [StatusWidth-1:0] ost_q, ost_d;
  logic [ValueWidth-1:0] oel_q, oel_d;
  logic                  olast_q, olast_d;

  logic                  we;
  logic [AW-1:0]         waddr, wlink, raddr, rlink;
  logic [WORD_WIDTH-1:0] wword, rword;

  bpl_mem #(.DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wword_i(wword), .wlink_i(wlink),
    .raddr_i(raddr), .rword_o(rword), .rlink_o(rlink)
  );

  logic [AW-1:0] low_free;
  always_comb begin
    low_free = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_q[i]) low_free = AW'(i);
    end
  end

  logic [PosWidth-1:0] pos_b, cnt_p;
  logic pos_neg, pos_zero;
  logic full, empty, out_free, req_fire;
  logic op_ins, op_del, op_dump;
  logic [WORD_WIDTH-1:0] in_word;
  assign pos_b = req.slot_index;
  assign pos_neg = req.slot_index[PosWidth-1];
  assign pos_zero = (pos_b == '0);
  assign cnt_p = PosWidth'(cnt_q);
  assign in_word = WORD_WIDTH'(req.item_value);
  assign full = (cnt_q == CW'(DEPTH));
  assign empty = (cnt_q == '0);
  assign out_free = !ovalid_q || rsp.ready;
  assign req.ready = (state_q == S_IDLE) && out_free;
  assign req_fire = req.valid && req.ready;
  assign op_ins = (req.opcode == OP_APPEND) || (req.opcode == OP_INSERT);
  assign op_del = (req.opcode == OP_DEL_FRONT) || (req.opcode == OP_DEL_END)
                  || (req.opcode == OP_DEL_POS);
  assign op_dump = (req.opcode == OP_DUMP);

  // Decode the target position and the immediate outcome of a request.
  logic                   req_err;
  logic [StatusWidth-1:0] err_st;
  logic [CW-1:0]          tpos;
  always_comb begin
    req_err = 1'b0; err_st = ST_OK; tpos = '0;
    case (req.opcode)
      OP_APPEND: begin
        if (full) begin
          req_err = 1'b1; err_st = ST_FULL;
        end else tpos = cnt_q;
      end
      OP_INSERT: begin
        if (full) begin
          req_err = 1'b1; err_st = ST_FULL;
        end else if (empty || pos_zero) tpos = '0;
        else if (pos_neg) tpos = CW'(1);
        else if (pos_b > cnt_p) begin
          req_err = 1'b1; err_st = ST_RANGE;
        end else tpos = pos_b[CW-1:0];
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          req_err = 1'b1; err_st = ST_EMPTY;
        end
      end
      OP_DEL_END: begin
        if (empty) begin
          req_err = 1'b1; err_st = ST_EMPTY;
        end else tpos = cnt_q - 1'b1;
      end
      OP_DEL_POS: begin
        if (empty) begin
          req_err = 1'b1; err_st = ST_EMPTY;
        end else if (pos_neg) begin
          req_err = 1'b1; err_st = ST_NEG;
        end else if (pos_b >= cnt_p) begin
          req_err = 1'b1; err_st = ST_RANGE;
        end else tpos = pos_b[CW-1:0];
      end
      OP_DUMP: begin
        if (empty) begin
          req_err = 1'b1; err_st = ST_EMPTY;
        end
      end
      default: req_err = 1'b1;
    endcase
  end

  function automatic logic [ValueWidth-1:0] sext(input logic [WORD_WIDTH-1:0] w);
    logic signed [63:0] t;
    t = 64'($signed(w));
    return t[ValueWidth-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire && !req_err) begin
          if (op_dump) state_d = S_DUMP;
          else if (op_del || tpos != '0) state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (front_q) state_d = S_IDLE;
        else if (idx_q == steps_q) state_d = S_LINK;
      end
      S_LINK: state_d = S_IDLE;
      S_DUMP: begin
        if (out_free && idx_q == cnt_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_d = head_q; free_d = free_q; cnt_d = cnt_q;
    steps_d = steps_q; idx_d = idx_q; cur_d = cur_q; ins_d = ins_q; front_d = front_q;
    val_d = val_q; nslot_d = nslot_q;
    ovalid_d = ovalid_q && !rsp.ready;
    ost_d = ost_q; oel_d = oel_q; olast_d = olast_q;
    we = 1'b0; waddr = nslot_q; wword = val_q; wlink = rlink; raddr = cur_q;
    case (state_q)
      S_IDLE: begin
        raddr = head_q;
        if (req_fire) begin
          ost_d = err_st; oel_d = '0; olast_d = 1'b1;
          val_d = in_word; nslot_d = low_free; cur_d = head_q; idx_d = '0;
          ins_d = op_ins; front_d = (tpos == '0); steps_d = tpos - 1'b1;
          if (req_err) begin
            ovalid_d = 1'b1;
          end else if (op_dump) begin
            idx_d = CW'(1);
          end else if (op_ins && tpos == '0) begin
            we = 1'b1; waddr = low_free; wword = in_word; wlink = head_q;
            head_d = low_free; free_d[low_free] = 1'b0; cnt_d = cnt_q + 1'b1;
            ovalid_d = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (front_q) begin
          head_d = rlink; free_d[cur_q] = 1'b1; cnt_d = cnt_q - 1'b1; ovalid_d = 1'b1;
        end else if (idx_q == steps_q) begin
          if (ins_q) begin
            we = 1'b1; waddr = nslot_q; wword = val_q; wlink = rlink;
          end else begin
            nslot_d = rlink; raddr = rlink;
          end
        end else begin
          cur_d = rlink; raddr = rlink; idx_d = idx_q + 1'b1;
        end
      end
      S_LINK: begin
        we = 1'b1; waddr = cur_q; wword = pword_q;
        if (ins_q) begin
          wlink = nslot_q; free_d[nslot_q] = 1'b0; cnt_d = cnt_q + 1'b1;
        end else begin
          wlink = rlink; free_d[nslot_q] = 1'b1; cnt_d = cnt_q - 1'b1;
        end
        ovalid_d = 1'b1;
      end
      S_DUMP: begin
        if (out_free) begin
          ovalid_d = 1'b1; ost_d = ST_OK; oel_d = sext(rword);
          olast_d = (idx_q == cnt_q);
          raddr = rlink; cur_d = rlink; idx_d = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic [WORD_WIDTH-1:0] pword_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_WALK) pword_q <= rword;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; head_q <= '0; free_q <= '1; cnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; free_q <= free_d; cnt_q <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d; idx_q <= idx_d; cur_q <= cur_d; ins_q <= ins_d;
    front_q <= front_d; val_q <= val_d; nslot_q <= nslot_d;
    ost_q <= ost_d; oel_q <= oel_d; olast_q <= olast_d;
  end

  assign rsp.valid = ovalid_q;
  assign rsp.status = ost_q;
  assign rsp.element = oel_q;
  assign rsp.element_count = CountWidth'(cnt_q);
  assign rsp.last_of_run = olast_q;

endmodule

// ===== test/bounded_positional_list_unit_test.sv =====
// Self-checking testbench for the bounded positional list unit.
`timescale 1ns / 100ps

module bounded_positional_list_unit_test;
  import bpl_pkg::*;

  localparam int unsigned ListDepth = 32;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    status_e               status;
    logic signed [31:0]    element;
    logic [CountWidth-1:0] count;
    logic                  last;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bpl_req_if req ();
  bpl_rsp_if rsp ();

  bounded_positional_list_unit #(
    .DEPTH(ListDepth),
    .WORD_WIDTH(32)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req(req),
    .rsp(rsp)
  );

  logic signed [31:0] list_words[$];
  list_result_t       expected_results[$];
  int unsigned        cycle_count = 0;
  int unsigned        error_count = 0;
  int unsigned        rsp_stall = 0;
  bit                 rsp_hold = 1'b0;
  bit                 no_idle = 1'b0;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall per beat, plus a long hold-off when asked.
  always @(negedge clk_i) begin
    if (rsp_hold) begin
      rsp.ready = 1'b0;
    end else if (rsp_stall > 0) begin
      rsp.ready = 1'b0;
      rsp_stall = rsp_stall - 1;
    end else begin
      rsp.ready = 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && rsp.valid && rsp.ready) begin
      rsp_stall = no_idle ? 0 : $urandom_range(0, 3);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected beat: status %0d element %0d count %0d last %0b", $time,
                 rsp.status, rsp.element, rsp.element_count, rsp.last_of_run);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp.status !== exp_r.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_r.status, rsp.status);
          error_count++;
        end
        if (rsp.element !== exp_r.element) begin
          $display("%0t element: expected %0d actual %0d", $time, exp_r.element, rsp.element);
          error_count++;
        end
        if (rsp.element_count !== exp_r.count) begin
          $display("%0t element_count: expected %0d actual %0d", $time, exp_r.count,
                   rsp.element_count);
          error_count++;
        end
        if (rsp.last_of_run !== exp_r.last) begin
          $display("%0t last_of_run: expected %0b actual %0b", $time, exp_r.last,
                   rsp.last_of_run);
          error_count++;
        end
      end
    end
  end

  function automatic list_result_t make_result(status_e st, logic signed [31:0] el, bit last);
    list_result_t r;
    r.status = st;
    r.element = el;
    r.count = CountWidth'(list_words.size());
    r.last = last;
    return r;
  endfunction

  // Apply one request to the list copy and queue the beats it produces.
  function automatic void apply_list_op(op_e op, logic signed [31:0] value,
                                        logic signed [15:0] pos);
    status_e st;
    int      n;
    st = ST_OK;
    n = list_words.size();
    case (op)
      OP_APPEND: begin
        if (n >= ListDepth) st = ST_FULL;
        else list_words.push_back(value);
      end
      OP_INSERT: begin
        if (n >= ListDepth) st = ST_FULL;
        else if (n == 0 || pos == 0) list_words.push_front(value);
        else if (pos < 0) list_words.insert(1, value);
        else if (pos > n) st = ST_RANGE;
        else list_words.insert(pos, value);
      end
      OP_DEL_FRONT: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_words.pop_front());
      end
      OP_DEL_END: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_words.pop_back());
      end
      OP_DEL_POS: begin
        if (n == 0) st = ST_EMPTY;
        else if (pos < 0) st = ST_NEG;
        else if (pos >= n) st = ST_RANGE;
        else list_words.delete(pos);
      end
      OP_DUMP: begin
        if (n == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          foreach (list_words[i])
            expected_results.push_back(make_result(ST_OK, list_words[i], i == n - 1));
        end
        return;
      end
      default: ;
    endcase
    expected_results.push_back(make_result(st, '0, 1'b1));
  endfunction

  task automatic send_request(op_e op, logic signed [31:0] value, logic signed [15:0] pos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      req.valid = 1'b0;
    end
    @(negedge clk_i);
    req.valid = 1'b1;
    req.opcode = op;
    req.item_value = value;
    req.slot_index = pos;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    apply_list_op(op, value, pos);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_list();
    send_request(OP_DEL_FRONT, 32'sd0, 16'sd0);
    send_request(OP_DEL_END, 32'sd0, 16'sd0);
    send_request(OP_DEL_POS, 32'sd0, -16'sd32768);
    send_request(OP_DUMP, 32'sd0, 16'sd0);
    send_request(OP_INSERT, 32'h8000_0000, 16'sd32767);
    send_request(OP_DEL_POS, 32'sd0, -16'sd1);
    send_request(OP_DEL_POS, 32'sd0, 16'sd1);
    send_request(OP_INSERT, 32'h7fff_ffff, 16'sd5);
    send_request(OP_INSERT, -32'sd1, -16'sd32768);
    send_request(OP_INSERT, 32'sd17, 16'sd0);
    send_request(OP_APPEND, 32'h5555_aaaa, 16'sd0);
    send_request(OP_INSERT, 32'haaaa_5555, 16'sd2);
    send_request(OP_DUMP, 32'sd0, 16'sd0);
    send_request(OP_DEL_POS, 32'sd0, 16'sd32767);
    send_request(OP_DEL_POS, 32'sd0, 16'sd2);
    send_request(OP_DEL_END, 32'sd0, 16'sd0);
    send_request(OP_DEL_FRONT, 32'sd0, 16'sd0);
    send_request(OP_DUMP, 32'sd0, 16'sd0);
  endtask

  task automatic test_full_list();
    while (list_words.size() < ListDepth)
      send_request(OP_APPEND, $urandom, 16'($urandom));
    send_request(OP_APPEND, 32'sd1, 16'sd0);
    send_request(OP_INSERT, 32'sd2, 16'sd0);
    send_request(OP_DUMP, 32'sd0, 16'sd0);
    send_request(OP_DEL_POS, 32'sd0, 16'(ListDepth - 1));
    send_request(OP_INSERT, 32'sd3, 16'(ListDepth - 1));
    send_request(OP_DEL_POS, 32'sd0, 16'sd0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        rsp_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        rsp_hold = 1'b0;
      end
      begin
        repeat (6) send_request(OP_DEL_END, 32'sd0, 16'sd0);
        send_request(OP_DUMP, 32'sd0, 16'sd0);
      end
    join
  endtask

  task automatic test_random_ops(int unsigned count, int unsigned grow_weight);
    op_e                op;
    logic signed [15:0] pos;
    int unsigned        pick;
    int                 n;
    repeat (count) begin
      n = list_words.size();
      pick = $urandom_range(0, 99);
      if (pick < grow_weight) op = ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
      else if (pick < 90) op = op_e'($urandom_range(2, 4));
      else op = OP_DUMP;
      if ($urandom_range(0, 9) == 0) pos = 16'($urandom);
      else pos = 16'($urandom_range(0, n));
      send_request(op, $urandom, pos);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_APPEND;
    req.item_value = '0;
    req.slot_index = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_list();
    test_full_list();
    test_backpressure();
    test_random_ops(60, 60);
    no_idle = 1'b1;
    test_random_ops(30, 50);
    no_idle = 1'b0;
    test_random_ops(60, 35);
    test_full_list();
    test_random_ops(30, 40);
    @(negedge clk_i);
    req.valid = 1'b0;
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
